// File: hdl/rcts_pkg.sv
// Shared types and constants for the relay contact test sequencer.
// Holds the request and result structs, the one-hot stage type and timing constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rcts_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_IDX_W   = 3;
  localparam int WAIT_W      = 7;
  localparam int BLINK_W     = 5;
  localparam int BCNT_W      = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_MIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSED_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_FRAME  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_SHORT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_VOLT   = 3'd4;

  // Countdown loads, in 100 ms ticks.
  localparam logic [WAIT_W-1:0] WAIT_SHORT = 7'd15;
  localparam logic [WAIT_W-1:0] WAIT_VOLT  = 7'd100;
  localparam logic [WAIT_W-1:0] WAIT_PASS  = 7'd50;

  localparam logic [BLINK_W-1:0] BLINK_ON_TICKS  = 5'd10;
  localparam logic [BLINK_W-1:0] BLINK_GAP_TICKS = 5'd10;
  localparam logic [BLINK_W-1:0] GROUP_GAP_TICKS = 5'd30;

  // Fault codes.
  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_FRAME = 2'd1;
  localparam logic [1:0] FAULT_SHORT = 2'd2;
  localparam logic [1:0] FAULT_VOLT  = 2'd3;

  // Stage codes as reported on the result channel.
  localparam logic [3:0] CODE_IDLE    = 4'd0;
  localparam logic [3:0] CODE_FRAME   = 4'd1;
  localparam logic [3:0] CODE_RELAY_P = 4'd2;
  localparam logic [3:0] CODE_SHORT_W = 4'd3;
  localparam logic [3:0] CODE_RELAY_N = 4'd4;
  localparam logic [3:0] CODE_VOLT_W  = 4'd5;
  localparam logic [3:0] CODE_OFF     = 4'd6;
  localparam logic [3:0] CODE_PASS    = 4'd7;
  localparam logic [3:0] CODE_FAIL    = 4'd8;
  localparam logic [3:0] CODE_RELEASE = 4'd9;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_FRAME   = 10'b00_0000_0010,
    ST_RELAY_P = 10'b00_0000_0100,
    ST_SHORT_W = 10'b00_0000_1000,
    ST_RELAY_N = 10'b00_0001_0000,
    ST_VOLT_W  = 10'b00_0010_0000,
    ST_OFF     = 10'b00_0100_0000,
    ST_PASS    = 10'b00_1000_0000,
    ST_FAIL    = 10'b01_0000_0000,
    ST_RELEASE = 10'b10_0000_0000
  } stage_t;

  typedef struct packed {
    logic                   tick_fast;
    logic                   tick_slow;
    logic                   button_down;
    logic                   frame_connected;
    logic [SAMPLE_BITS-1:0] voltage_a;
    logic [SAMPLE_BITS-1:0] voltage_b;
  } in_item_t;

  typedef struct packed {
    logic       relay_positive;
    logic       relay_negative;
    logic       led_green;
    logic       led_red;
    logic [3:0] stage;
    logic [1:0] fault;
  } out_item_t;

  function automatic logic [3:0] stage_code(input stage_t st);
    logic [3:0] code;
    case (st)
      ST_IDLE:    code = CODE_IDLE;
      ST_FRAME:   code = CODE_FRAME;
      ST_RELAY_P: code = CODE_RELAY_P;
      ST_SHORT_W: code = CODE_SHORT_W;
      ST_RELAY_N: code = CODE_RELAY_N;
      ST_VOLT_W:  code = CODE_VOLT_W;
      ST_OFF:     code = CODE_OFF;
      ST_PASS:    code = CODE_PASS;
      ST_FAIL:    code = CODE_FAIL;
      ST_RELEASE: code = CODE_RELEASE;
      default:    code = CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// File: hdl/rcts_button.sv
// Button hold counter and press latch for the relay contact test sequencer.
// A press is reported once on release after the button was held long enough.
// Depends on rcts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcts_button
  import rcts_pkg::*;
#(
  parameter int HOLD_LIMIT = 100
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic step_en,
  input  wire logic button_down,
  output logic      press_event
);

  localparam int HW = $clog2(HOLD_LIMIT + 2);
  localparam logic [HW-1:0] HOLD_MAX = HW'(HOLD_LIMIT);

  logic [HW-1:0] hold_r, hold_nxt;
  logic          latch_r, latch_nxt;

  always_comb begin
    hold_nxt    = hold_r;
    latch_nxt   = latch_r;
    press_event = 1'b0;
    if (button_down) begin
      if (hold_r > HOLD_MAX) begin
        latch_nxt = 1'b1;
      end else begin
        hold_nxt = hold_r + 1'b1;
      end
    end else begin
      hold_nxt    = '0;
      press_event = latch_r;
      latch_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r  <= '0;
      latch_r <= 1'b0;
    end else if (step_en) begin
      hold_r  <= hold_nxt;
      latch_r <= latch_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/rcts_blink.sv
// Red LED blink-code generator used while the sequencer sits in the fail stage.
// Blinks the configured count per group, with a longer gap between groups.
// Depends on rcts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcts_blink
  import rcts_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step_en,
  input  wire logic              clear,
  input  wire logic [BCNT_W-1:0] groups,
  input  wire logic              tick,
  output logic                   red_we,
  output logic                   red_val
);

  logic               phase_r, phase_nxt, phase_c;
  logic [BLINK_W-1:0] timer_r, timer_nxt, timer_c;
  logic [BCNT_W-1:0]  count_r, count_nxt, count_c;

  // A first step in the fail stage starts from a cleared pattern.
  assign phase_c = clear ? 1'b0 : phase_r;
  assign timer_c = clear ? '0 : timer_r;
  assign count_c = clear ? '0 : count_r;

  always_comb begin
    phase_nxt = phase_c;
    timer_nxt = timer_c;
    count_nxt = count_c;
    red_we    = 1'b0;
    red_val   = 1'b0;
    if (groups == '0) begin
      phase_nxt = 1'b0;
      timer_nxt = '0;
      count_nxt = '0;
    end else begin
      if (tick && timer_c != '0) begin
        timer_nxt = timer_c - 1'b1;
      end
      if (timer_nxt == '0) begin
        phase_nxt = !phase_c;
        red_we    = 1'b1;
        if (phase_c) begin
          red_val   = 1'b1;
          count_nxt = count_c + 1'b1;
          timer_nxt = BLINK_ON_TICKS;
        end else if (count_c < groups) begin
          timer_nxt = BLINK_GAP_TICKS;
        end else begin
          count_nxt = '0;
          timer_nxt = GROUP_GAP_TICKS;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      timer_r <= '0;
      count_r <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/relay_contact_test_sequencer_unit.sv
// Timing: an accepted request is held in the input register; its result is registered
// in the result register when it advances and is then taken from the result channel.
// Throughput: one request per cycle while out_ready is not held low; the input register
// refills in the same cycle its request moves into the result register.
// Reset (synchronous, rst_n low) returns the sequencer to idle with relays open,
// LEDs off, counters cleared and the configuration registers at their defaults.
`timescale 1ns / 1ps
`default_nettype none

module relay_contact_test_sequencer_unit
  import rcts_pkg::*;
#(
  parameter int HOLD_LIMIT = 100
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic [SAMPLE_BITS-1:0] open_min_r, closed_max_r;
  logic [BCNT_W-1:0]      blk_frame_r, blk_short_r, blk_volt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_min_r   <= SAMPLE_BITS'(2048);
      closed_max_r <= SAMPLE_BITS'(1024);
      blk_frame_r  <= BCNT_W'(1);
      blk_short_r  <= BCNT_W'(2);
      blk_volt_r   <= BCNT_W'(3);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OPEN_MIN:    open_min_r   <= cfg_wdata[SAMPLE_BITS-1:0];
        CFG_CLOSED_MAX:  closed_max_r <= cfg_wdata[SAMPLE_BITS-1:0];
        CFG_BLINK_FRAME: blk_frame_r  <= cfg_wdata[BCNT_W-1:0];
        CFG_BLINK_SHORT: blk_short_r  <= cfg_wdata[BCNT_W-1:0];
        CFG_BLINK_VOLT:  blk_volt_r   <= cfg_wdata[BCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register and handshake.
  logic     in_valid_r;
  in_item_t in_data_r;
  logic     out_valid_r;
  out_item_t out_data_r, out_data_nxt;
  logic     adv;

  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  // Sequencer state.
  stage_t            stage_r, stage_nxt;
  logic [1:0]        fault_r, fault_nxt;
  logic [WAIT_W-1:0] wait_r, wait_nxt, wait_dec;
  logic              fail_ent_r, fail_ent_nxt;
  logic              green_r, green_nxt;
  logic              red_r, red_nxt;
  logic              rpos_r, rpos_nxt;
  logic              rneg_r, rneg_nxt;

  logic              btn_step, press_event;
  logic              blink_step, blink_clear;
  logic [BCNT_W-1:0] blink_groups;
  logic              red_we, red_val;
  logic              volt_open_ok, volt_closed_ok;

  assign btn_step = adv && (stage_r == ST_IDLE || stage_r == ST_FAIL ||
                            stage_r == ST_RELEASE);
  assign blink_step  = adv && (stage_r == ST_FAIL);
  assign blink_clear = !fail_ent_r;

  always_comb begin
    case (fault_r)
      FAULT_FRAME: blink_groups = blk_frame_r;
      FAULT_SHORT: blink_groups = blk_short_r;
      FAULT_VOLT:  blink_groups = blk_volt_r;
      default:     blink_groups = '0;
    endcase
  end

  rcts_button #(
    .HOLD_LIMIT(HOLD_LIMIT)
  ) u_button (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (btn_step),
    .button_down(in_data_r.button_down),
    .press_event(press_event)
  );

  rcts_blink u_blink (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(blink_step),
    .clear  (blink_clear),
    .groups (blink_groups),
    .tick   (in_data_r.tick_fast),
    .red_we (red_we),
    .red_val(red_val)
  );

  assign wait_dec = (in_data_r.tick_fast && wait_r != '0) ? wait_r - 1'b1 : wait_r;

  assign volt_open_ok   = (in_data_r.voltage_a > open_min_r) &&
                          (in_data_r.voltage_b > open_min_r);
  assign volt_closed_ok = (in_data_r.voltage_a < closed_max_r) &&
                          (in_data_r.voltage_b < closed_max_r);

  always_comb begin
    stage_nxt    = stage_r;
    fault_nxt    = fault_r;
    wait_nxt     = wait_dec;
    fail_ent_nxt = fail_ent_r;
    green_nxt    = green_r;
    red_nxt      = red_r;
    rpos_nxt     = rpos_r;
    rneg_nxt     = rneg_r;
    case (stage_r)
      ST_IDLE: begin
        red_nxt = 1'b0;
        if (in_data_r.tick_slow) begin
          green_nxt = !green_r;
        end
        if (press_event) begin
          stage_nxt = ST_FRAME;
        end
      end
      ST_FRAME: begin
        if (in_data_r.frame_connected) begin
          stage_nxt = ST_RELAY_P;
        end else begin
          fault_nxt = FAULT_FRAME;
          stage_nxt = ST_FAIL;
        end
      end
      ST_RELAY_P: begin
        rpos_nxt  = 1'b1;
        wait_nxt  = WAIT_SHORT;
        stage_nxt = ST_SHORT_W;
      end
      ST_SHORT_W: begin
        if (in_data_r.tick_fast) begin
          green_nxt = !green_r;
        end
        if (wait_dec == '0) begin
          if (volt_open_ok) begin
            stage_nxt = ST_RELAY_N;
          end else begin
            fault_nxt = FAULT_SHORT;
            stage_nxt = ST_FAIL;
          end
        end
      end
      ST_RELAY_N: begin
        rneg_nxt  = 1'b1;
        wait_nxt  = WAIT_VOLT;
        stage_nxt = ST_VOLT_W;
      end
      ST_VOLT_W: begin
        if (in_data_r.tick_fast) begin
          green_nxt = !green_r;
        end
        if (wait_dec == '0) begin
          if (volt_closed_ok) begin
            stage_nxt = ST_OFF;
          end else begin
            fault_nxt = FAULT_VOLT;
            stage_nxt = ST_FAIL;
          end
        end
      end
      ST_OFF: begin
        wait_nxt  = WAIT_PASS;
        rpos_nxt  = 1'b0;
        rneg_nxt  = 1'b0;
        stage_nxt = ST_PASS;
      end
      ST_PASS: begin
        red_nxt   = 1'b0;
        green_nxt = 1'b1;
        if (wait_dec == '0) begin
          green_nxt = 1'b0;
          stage_nxt = ST_IDLE;
        end
      end
      ST_FAIL: begin
        // The first step in this stage drops the relays and the green LED.
        if (!fail_ent_r) begin
          fail_ent_nxt = 1'b1;
          green_nxt    = 1'b0;
          rpos_nxt     = 1'b0;
          rneg_nxt     = 1'b0;
        end
        if (red_we) begin
          red_nxt = red_val;
        end
        if (press_event) begin
          fail_ent_nxt = 1'b0;
          stage_nxt    = ST_RELEASE;
        end
      end
      ST_RELEASE: begin
        if (!press_event) begin
          stage_nxt = ST_IDLE;
        end
      end
      default: begin
        wait_nxt = wait_dec;
      end
    endcase
  end

  always_comb begin
    out_data_nxt.relay_positive = rpos_nxt;
    out_data_nxt.relay_negative = rneg_nxt;
    out_data_nxt.led_green      = green_nxt;
    out_data_nxt.led_red        = red_nxt;
    out_data_nxt.stage          = stage_code(stage_nxt);
    out_data_nxt.fault          = fault_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r    <= ST_IDLE;
      fault_r    <= FAULT_NONE;
      wait_r     <= '0;
      fail_ent_r <= 1'b0;
      green_r    <= 1'b0;
      red_r      <= 1'b0;
      rpos_r     <= 1'b0;
      rneg_r     <= 1'b0;
    end else if (adv) begin
      stage_r    <= stage_nxt;
      fault_r    <= fault_nxt;
      wait_r     <= wait_nxt;
      fail_ent_r <= fail_ent_nxt;
      green_r    <= green_nxt;
      red_r      <= red_nxt;
      rpos_r     <= rpos_nxt;
      rneg_r     <= rneg_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: hdl/rcts_checker.sv
// Port-level checks for the relay contact test sequencer, bound to the top level.
// Depends on rcts_pkg and relay_contact_test_sequencer_unit.
`timescale 1ns / 1ps
`default_nettype none

module rcts_checker
  import rcts_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire in_item_t              in_data,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire out_item_t             out_data,
  input wire logic                  cfg_we,
  input wire logic [CFG_IDX_W-1:0]  cfg_index,
  input wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // The negative relay is never closed without the positive one.
  a_relay_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.relay_negative || out_data.relay_positive))
    else $error("negative relay closed while positive relay open");

  // Fail and release stages always carry a fault code.
  a_fault_in_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.stage == CODE_FAIL || out_data.stage == CODE_RELEASE))
      |-> (out_data.fault != FAULT_NONE))
    else $error("fail stage reported without a fault code");

  // The red LED is only lit while a failure is shown, and it is still lit on the
  // request that leaves the release stage for idle.
  a_red_only_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.led_red)
      |-> (out_data.stage == CODE_FAIL || out_data.stage == CODE_RELEASE ||
           out_data.stage == CODE_IDLE))
    else $error("red LED lit outside the fail stages");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed or dropped while stalled");

endmodule

bind relay_contact_test_sequencer_unit rcts_checker u_rcts_checker (.*);

`default_nettype wire

// File: test/relay_sequencer_checker.sv
// Checker for the relay contact test sequencer: follows configuration writes, predicts the
// result of every accepted request and compares it with the result channel.
// Depends on rcts_pkg for the payload types, stage codes, fault codes and timing constants.
`timescale 1ns / 1ps

module relay_sequencer_checker
  import rcts_pkg::*;
#(
  parameter int HOLD_LIMIT = 100
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    pending,
  output int                    failures
);

  logic [SAMPLE_BITS-1:0] open_min, closed_max;
  logic [3:0]             blinks_frame, blinks_short, blinks_volt;

  logic [3:0]         seq_stage;
  logic [1:0]         seq_fault;
  logic [WAIT_W-1:0]  wait_left;
  logic [6:0]         hold_len;
  bit                 press_seen, fail_armed, blink_phase;
  logic [BLINK_W-1:0] blink_left;
  logic [BCNT_W-1:0]  blink_done;
  bit                 green, red, relay_p, relay_n;

  out_item_t expected_results[$];
  out_item_t want;

  // A press counts only once the button has been held past the limit, and it is
  // reported on the first request with the button up.
  function automatic bit button_released(input bit down);
    if (down) begin
      if (hold_len > HOLD_LIMIT) press_seen = 1'b1;
      else hold_len = hold_len + 1'b1;
      return 1'b0;
    end
    hold_len = '0;
    if (press_seen) begin
      press_seen = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void blink_reset();
    blink_phase = 1'b0;
    blink_left  = '0;
    blink_done  = '0;
  endfunction

  function automatic out_item_t advance_sequencer(input in_item_t req);
    out_item_t res;
    logic [3:0] groups;
    if (req.tick_fast && wait_left != 0) wait_left = wait_left - 1'b1;
    case (seq_stage)
      CODE_IDLE: begin
        red = 1'b0;
        if (req.tick_slow) green = !green;
        if (button_released(req.button_down)) seq_stage = CODE_FRAME;
      end
      CODE_FRAME: begin
        if (req.frame_connected) begin
          seq_stage = CODE_RELAY_P;
        end else begin
          seq_fault = FAULT_FRAME;
          seq_stage = CODE_FAIL;
        end
      end
      CODE_RELAY_P: begin
        relay_p   = 1'b1;
        wait_left = WAIT_SHORT;
        seq_stage = CODE_SHORT_W;
      end
      CODE_SHORT_W: begin
        if (req.tick_fast) green = !green;
        if (wait_left == 0) begin
          if (req.voltage_a > open_min && req.voltage_b > open_min) begin
            seq_stage = CODE_RELAY_N;
          end else begin
            seq_fault = FAULT_SHORT;
            seq_stage = CODE_FAIL;
          end
        end
      end
      CODE_RELAY_N: begin
        relay_n   = 1'b1;
        wait_left = WAIT_VOLT;
        seq_stage = CODE_VOLT_W;
      end
      CODE_VOLT_W: begin
        if (req.tick_fast) green = !green;
        if (wait_left == 0) begin
          if (req.voltage_a < closed_max && req.voltage_b < closed_max) begin
            seq_stage = CODE_OFF;
          end else begin
            seq_fault = FAULT_VOLT;
            seq_stage = CODE_FAIL;
          end
        end
      end
      CODE_OFF: begin
        wait_left = WAIT_PASS;
        relay_p   = 1'b0;
        relay_n   = 1'b0;
        seq_stage = CODE_PASS;
      end
      CODE_PASS: begin
        red   = 1'b0;
        green = 1'b1;
        if (wait_left == 0) begin
          green     = 1'b0;
          seq_stage = CODE_IDLE;
        end
      end
      CODE_FAIL: begin
        if (!fail_armed) begin
          fail_armed = 1'b1;
          green      = 1'b0;
          relay_p    = 1'b0;
          relay_n    = 1'b0;
          blink_reset();
        end
        case (seq_fault)
          FAULT_FRAME: groups = blinks_frame;
          FAULT_SHORT: groups = blinks_short;
          FAULT_VOLT:  groups = blinks_volt;
          default:     groups = '0;
        endcase
        // A zero group size stops the blinking but keeps the red LED as it is.
        if (groups == 0) begin
          blink_reset();
        end else begin
          if (req.tick_fast && blink_left != 0) blink_left = blink_left - 1'b1;
          if (blink_left == 0) begin
            blink_phase = !blink_phase;
            if (!blink_phase) begin
              red        = 1'b1;
              blink_done = blink_done + 1'b1;
              blink_left = BLINK_ON_TICKS;
            end else begin
              red = 1'b0;
              if (blink_done < groups) begin
                blink_left = BLINK_GAP_TICKS;
              end else begin
                blink_done = '0;
                blink_left = GROUP_GAP_TICKS;
              end
            end
          end
        end
        if (button_released(req.button_down)) begin
          fail_armed = 1'b0;
          seq_stage  = CODE_RELEASE;
        end
      end
      CODE_RELEASE: begin
        if (!button_released(req.button_down)) seq_stage = CODE_IDLE;
      end
      default: begin
      end
    endcase
    res.relay_positive = relay_p;
    res.relay_negative = relay_n;
    res.led_green      = green;
    res.led_red        = red;
    res.stage          = seq_stage;
    res.fault          = seq_fault;
    return res;
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v, got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      open_min     = 12'd2048;
      closed_max   = 12'd1024;
      blinks_frame = 4'd1;
      blinks_short = 4'd2;
      blinks_volt  = 4'd3;
      seq_stage    = CODE_IDLE;
      seq_fault    = FAULT_NONE;
      wait_left    = '0;
      hold_len     = '0;
      press_seen   = 1'b0;
      fail_armed   = 1'b0;
      blink_reset();
      green        = 1'b0;
      red          = 1'b0;
      relay_p      = 1'b0;
      relay_n      = 1'b0;
      expected_results.delete();
      failures     = 0;
      pending     <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_OPEN_MIN:    open_min     = cfg_wdata;
          CFG_CLOSED_MAX:  closed_max   = cfg_wdata;
          CFG_BLINK_FRAME: blinks_frame = cfg_wdata[3:0];
          CFG_BLINK_SHORT: blinks_short = cfg_wdata[3:0];
          CFG_BLINK_VOLT:  blinks_volt  = cfg_wdata[3:0];
          default: begin
          end
        endcase
      end
      // Retire the oldest expectation before adding this edge's request, so that a
      // result arriving with nothing outstanding is caught.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          failures++;
        end else begin
          want = expected_results.pop_front();
          check_field("relay_positive", want.relay_positive, out_data.relay_positive);
          check_field("relay_negative", want.relay_negative, out_data.relay_negative);
          check_field("led_green", want.led_green, out_data.led_green);
          check_field("led_red", want.led_red, out_data.led_red);
          check_field("stage", want.stage, out_data.stage);
          check_field("fault", want.fault, out_data.fault);
        end
      end
      if (in_valid && in_ready) expected_results.push_back(advance_sequencer(in_data));
      pending <= expected_results.size();
    end
  end

endmodule

// File: test/tb_relay_contact_test_sequencer_unit.sv
// Testbench top for relay_contact_test_sequencer_unit: drives test runs, faults and button
// noise with random idling on both channels, and reports the verdict.
// Depends on rcts_pkg, relay_sequencer_checker and the unit under test.
`timescale 1ns / 1ps

module tb_relay_contact_test_sequencer_unit;
  import rcts_pkg::*;

  localparam int HOLD_ITEMS = 100;

  typedef enum int {RUN_PASS, RUN_FRAME, RUN_SHORT, RUN_VOLT} run_kind_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int pending, failures;
  int items_sent = 0;
  int tf_total = 0;
  bit calm = 1'b0;
  int unsigned lo_a = 0, hi_a = 4095, lo_b = 0, hi_b = 4095;

  relay_contact_test_sequencer_unit #(.HOLD_LIMIT(HOLD_ITEMS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  relay_sequencer_checker #(.HOLD_LIMIT(HOLD_ITEMS)) seq_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .pending(pending), .failures(failures)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 35);
  end

  initial begin
    #4_000_000;
    $display("tb_relay_contact_test_sequencer_unit failed");
    $finish;
  end

  task automatic push_request(input bit tf, ts, btn, frame,
                              input logic [SAMPLE_BITS-1:0] va, vb);
    in_item_t req;
    bit       steady;
    req.tick_fast       = tf;
    req.tick_slow       = ts;
    req.button_down     = btn;
    req.frame_connected = frame;
    req.voltage_a       = va;
    req.voltage_b       = vb;
    steady = (items_sent >= 300) && (items_sent < 500);
    calm <= steady;
    while (!steady && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (tf) tf_total++;
  endtask

  task automatic band_request(input bit btn, frame, input int tf_pct);
    push_request($urandom_range(99) < tf_pct, 1'($urandom_range(1)), btn, frame,
                 SAMPLE_BITS'($urandom_range(hi_a, lo_a)),
                 SAMPLE_BITS'($urandom_range(hi_b, lo_b)));
  endtask

  // Button up, held for the given number of requests, then up again.
  task automatic hold_button(input int downs);
    band_request(1'b0, 1'($urandom_range(1)), 50);
    repeat (downs) band_request(1'b1, 1'($urandom_range(1)), 50);
    band_request(1'b0, 1'($urandom_range(1)), 50);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  function automatic logic [3:0] pick_blinks();
    case ($urandom_range(7))
      0: return 4'd0;
      1: return 4'd1;
      2: return 4'd15;
      default: return 4'($urandom_range(15, 1));
    endcase
  endfunction

  // Chooses thresholds and voltage bands so that the run ends the way its kind says.
  task automatic start_phase(input run_kind_t kind, input bit no_frame_blinks);
    int unsigned omin, cmax, t;
    logic [3:0]  bf, bs, bv;
    lo_a = 0; hi_a = 4095; lo_b = 0; hi_b = 4095;
    omin = $urandom_range(4095);
    cmax = $urandom_range(4095);
    case (kind)
      RUN_PASS: begin
        omin = $urandom_range(1) ? 0 : $urandom_range(2000);
        cmax = $urandom_range(1) ? 4095 : $urandom_range(4095, omin + 2);
        lo_a = omin + 1; hi_a = cmax - 1;
        lo_b = omin + 1; hi_b = cmax - 1;
      end
      RUN_SHORT: begin
        case ($urandom_range(2))
          0: omin = 4095;
          1: omin = 0;
          default: omin = $urandom_range(4095, 1);
        endcase
        hi_a = omin;
      end
      RUN_VOLT: begin
        if ($urandom_range(2) == 0) begin
          // Closed-circuit limit at or below the open-circuit one: both channels fail.
          cmax = $urandom_range(1) ? 0 : $urandom_range(4094);
          omin = $urandom_range(4094, cmax);
          lo_a = omin + 1; lo_b = omin + 1;
        end else begin
          omin = $urandom_range(3000);
          cmax = $urandom_range(4095, omin + 2);
          lo_a = cmax;
          if ($urandom_range(1)) begin
            lo_b = omin + 1; hi_b = cmax - 1;
          end else begin
            lo_b = cmax;
          end
        end
      end
      default: begin
      end
    endcase
    if ($urandom_range(1)) begin
      t = lo_a; lo_a = lo_b; lo_b = t;
      t = hi_a; hi_a = hi_b; hi_b = t;
    end
    bf = no_frame_blinks ? 4'd0 : pick_blinks();
    bs = pick_blinks();
    bv = pick_blinks();
    wait_idle();
    write_reg(CFG_OPEN_MIN, CFG_DATA_W'(omin));
    write_reg(CFG_CLOSED_MAX, CFG_DATA_W'(cmax));
    write_reg(CFG_BLINK_FRAME, {8'($urandom_range(255)), bf});
    write_reg(CFG_BLINK_SHORT, {8'($urandom_range(255)), bs});
    write_reg(CFG_BLINK_VOLT, {8'($urandom_range(255)), bv});
    cfg_we <= 1'b0;
  endtask

  task automatic test_run(input run_kind_t kind, input bit no_frame_blinks);
    int need, base;
    start_phase(kind, no_frame_blinks);
    hold_button($urandom_range(106, 102));
    // This request meets the frame check.
    band_request(1'b0, kind != RUN_FRAME, 90);
    case (kind)
      RUN_PASS:  need = 172;
      RUN_SHORT: need = 20;
      RUN_VOLT:  need = 122;
      default:   need = 0;
    endcase
    base = tf_total;
    while (tf_total - base < need) begin
      band_request($urandom_range(9) == 0, 1'($urandom_range(1)), 90);
    end
    if (kind != RUN_PASS) begin
      repeat ($urandom_range(60, 10)) begin
        band_request($urandom_range(9) == 0, 1'($urandom_range(1)), 90);
      end
      hold_button($urandom_range(106, 102));
      band_request(1'($urandom_range(1)), 1'($urandom_range(1)), 50);
    end
    repeat ($urandom_range(6, 3)) band_request(1'b0, 1'($urandom_range(1)), 50);
  endtask

  // Idle-stage noise: random requests and presses too short to start a run.
  task automatic idle_noise();
    lo_a = 0; hi_a = 4095; lo_b = 0; hi_b = 4095;
    repeat ($urandom_range(12, 6)) begin
      if ($urandom_range(4) == 0) begin
        case ($urandom_range(3))
          0: hold_button(HOLD_ITEMS);
          1: hold_button(HOLD_ITEMS + 1);
          default: hold_button($urandom_range(30, 1));
        endcase
      end else begin
        band_request(1'($urandom_range(1)), 1'($urandom_range(1)), 50);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_request(1'b0, 1'b0, 1'b0, 1'b0, 12'h000, 12'h000);
    push_request(1'b1, 1'b1, 1'b1, 1'b1, 12'hFFF, 12'hFFF);
    push_request(1'b0, 1'b1, 1'b0, 1'b1, 12'hFFF, 12'h000);
    push_request(1'b1, 1'b0, 1'b1, 1'b0, 12'h000, 12'hFFF);
    push_request(1'b1, 1'b1, 1'b0, 1'b0, 12'hAAA, 12'h555);
    push_request(1'b0, 1'b0, 1'b0, 1'b1, 12'h555, 12'hAAA);
    push_request(1'b0, 1'b1, 1'b0, 1'b0, 12'h800, 12'h7FF);
    push_request(1'b1, 1'b1, 1'b1, 1'b1, 12'h001, 12'hFFE);
    push_request(1'b0, 1'b0, 1'b0, 1'b0, 12'h400, 12'h3FF);

    idle_noise();
    test_run(RUN_FRAME, 1'b1);
    test_run(RUN_PASS, 1'b0);
    // Further idle noise and fault runs follow until 750 requests have been sent in all.
    while (items_sent < 750) begin
      if ($urandom_range(2) == 0) idle_noise();
      else test_run(run_kind_t'($urandom_range(3, 2)), 1'b0);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("tb_relay_contact_test_sequencer_unit passed");
    end else begin
      $display("tb_relay_contact_test_sequencer_unit failed");
    end
    $finish;
  end

endmodule
